FILE: hw/rtl/nfa_pkg.sv
package nfa_pkg;

    // input item opcodes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STEP  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SYMBOL_CODES   = 2'd0,
        CFG_SYMBOLS_IN_USE = 2'd1,
        CFG_FINAL_MASK     = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    localparam int CODES_W  = 64;
    localparam int NSYM_W   = 4;
    localparam int MASK_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int RSTATE_W = 4;
    localparam int RSYM_W   = 3;
    localparam int ACTIVE_W = 16;

    // symbol lookup result
    typedef struct packed {
        logic              hit;
        logic [RSYM_W-1:0] sym;
    } t_sym_match;

endpackage

FILE: hw/rtl/nfa_in_if.sv
interface nfa_in_if;
    logic                          valid;
    logic                          ready;
    nfa_pkg::t_op                  op;
    logic [nfa_pkg::CHAR_W-1:0]    char_byte;
    logic [nfa_pkg::RSTATE_W-1:0]  row_state;
    logic [nfa_pkg::RSYM_W-1:0]    row_symbol;
    logic [nfa_pkg::ACTIVE_W-1:0]  row_targets;

    modport source (output valid, op, char_byte, row_state, row_symbol, row_targets,
                    input ready);
    modport sink (input valid, op, char_byte, row_state, row_symbol, row_targets,
                  output ready);
endinterface

interface nfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [nfa_pkg::ACTIVE_W-1:0]  active_states;
    logic                          accepted;
    logic                          invalid;

    modport source (output valid, active_states, accepted, invalid, input ready);
    modport sink (input valid, active_states, accepted, invalid, output ready);
endinterface

interface nfa_cfg_if;
    logic                          valid;
    logic                          ready;
    nfa_pkg::t_cfg_index           index;
    logic [nfa_pkg::CODES_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/nfa_sym_match.sv
module nfa_sym_match #(
    parameter int SYMBOL_COUNT = 8
) (
    input  logic [nfa_pkg::CODES_W-1:0] i_symbol_codes,
    input  logic [nfa_pkg::NSYM_W-1:0]  i_symbols_in_use,
    input  logic [nfa_pkg::CHAR_W-1:0]  i_char,
    output nfa_pkg::t_sym_match         o_match
);
    import nfa_pkg::*;

    // lowest matching index wins, so scan from the top down
    always_comb begin
        o_match = '0;
        for (int j = SYMBOL_COUNT - 1; j >= 0; j--) begin
            if ((j < int'(i_symbols_in_use)) &&
                (i_symbol_codes[CHAR_W*j +: CHAR_W] == i_char)) begin
                o_match.hit = 1'b1;
                o_match.sym = RSYM_W'(j);
            end
        end
    end

endmodule

FILE: hw/rtl/nfa_row_mem.sv
module nfa_row_mem #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hw/rtl/nfa_state_set_simulator.sv
// NFA state-set simulator. The active set of an automaton with STATE_COUNT states is held
// as a bitmask; transition rows live in a STATE_COUNT*SYMBOL_COUNT entry memory with one
// write and one registered read port. After reset the block clears the row memory, one
// row a cycle, with input ready low (configuration writes are taken at all times). A
// start, load or unused-op item goes from transfer straight to presenting its result. A
// step item first matches the byte against the symbol codes, then issues one row memory
// read per state, in state order, through the single read port and ORs the rows of the
// active states into the next set, then drains the read pipeline and presents the result
// once the output register is free. One item is in work at a time; the next item may be
// transferred while the previous result still waits in the output register.
module nfa_state_set_simulator #(
    parameter int STATE_COUNT  = 16,
    parameter int SYMBOL_COUNT = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nfa_in_if.sink    i_in,
    nfa_out_if.source o_out,
    nfa_cfg_if.sink   i_cfg
);
    import nfa_pkg::*;

    localparam int TABLE_DEPTH = STATE_COUNT * SYMBOL_COUNT;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(STATE_COUNT);

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_MATCH = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [CODES_W-1:0] r_symbol_codes;
    logic [NSYM_W-1:0]  r_symbols_in_use;
    logic [MASK_W-1:0]  r_final_mask;

    // run state
    logic [STATE_COUNT-1:0] r_active, n_active;
    logic                   r_error, n_error;

    // scan datapath
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_pend, n_pend;
    logic [STATE_COUNT-1:0] r_acc, n_acc;
    logic [CHAR_W-1:0]      r_char;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [ACTIVE_W-1:0] r_out_active;
    logic                r_out_accepted;
    logic                r_out_invalid;

    logic                   in_xfer;
    logic                   load_ok;
    logic [ADDR_W-1:0]      load_addr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [STATE_COUNT-1:0] mem_wdata;
    logic [STATE_COUNT-1:0] mem_rdata;
    logic [STATE_COUNT-1:0] row_hit;
    logic                   out_free;
    t_sym_match             match;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    // loads outside the table are dropped
    assign load_ok   = (int'(i_in.row_state) < STATE_COUNT) &&
                       (int'(i_in.row_symbol) < SYMBOL_COUNT);
    assign load_addr = ADDR_W'(int'(i_in.row_state) * SYMBOL_COUNT + int'(i_in.row_symbol));

    // the clear pass owns the write port until it ends
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = in_xfer && (i_in.op == OP_LOAD) && load_ok;
            mem_waddr = load_addr;
            mem_wdata = STATE_COUNT'(i_in.row_targets);
        end
    end

    nfa_row_mem #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (STATE_COUNT),
        .ADDR_W (ADDR_W)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    nfa_sym_match #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_sym_match (
        .i_symbol_codes   (r_symbol_codes),
        .i_symbols_in_use (r_symbols_in_use),
        .i_char           (r_char),
        .o_match          (match)
    );

    // row returned this cycle counts only if its source state was active
    assign row_hit = r_pend ? mem_rdata : '0;

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_error     = r_error;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in.op)
                        OP_START: begin
                            n_active = STATE_COUNT'(1);
                            n_error  = 1'b0;
                            n_state  = S_EMIT;
                        end
                        OP_STEP: begin
                            n_state = S_MATCH;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_MATCH: begin
                // unknown byte leaves the set alone and flags the run
                n_cnt  = '0;
                n_pend = 1'b0;
                n_acc  = '0;
                n_addr = ADDR_W'(match.sym);
                if (match.hit) begin
                    n_state = S_SCAN;
                end else begin
                    n_error = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                // issue row read for state r_cnt, fold in the previous one
                n_acc  = r_acc | row_hit;
                n_pend = r_active[r_cnt];
                n_addr = r_addr + ADDR_W'(SYMBOL_COUNT);
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STATE_COUNT - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_active = r_acc | row_hit;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_active         <= STATE_COUNT'(1);
            r_error          <= 1'b0;
            r_addr           <= '0;
            r_cnt            <= '0;
            r_pend           <= 1'b0;
            r_out_valid      <= 1'b0;
            r_symbol_codes   <= '0;
            r_symbols_in_use <= '0;
            r_final_mask     <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_error     <= n_error;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SYMBOL_CODES:   r_symbol_codes   <= i_cfg.data;
                    CFG_SYMBOLS_IN_USE: r_symbols_in_use <= i_cfg.data[NSYM_W-1:0];
                    CFG_FINAL_MASK:     r_final_mask     <= i_cfg.data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (in_xfer) begin
            r_char <= i_in.char_byte;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_active   <= ACTIVE_W'(r_active);
            r_out_accepted <= (|(ACTIVE_W'(r_active) & r_final_mask)) && !r_error;
            r_out_invalid  <= r_error;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.active_states = r_out_active;
    assign o_out.accepted      = r_out_accepted;
    assign o_out.invalid       = r_out_invalid;

endmodule

FILE: hw/rtl/nfa_chk.sv
module nfa_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_accepted,
    input logic i_out_invalid
);

    // one item in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // row memory clear pass holds off input after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during row memory clear");

    // an invalid run is never accepted
    a_invalid_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_accepted && i_out_invalid))
        else $error("result both accepted and invalid");

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind nfa_state_set_simulator nfa_chk u_nfa_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_accepted (o_out.accepted),
    .i_out_invalid  (o_out.invalid)
);

FILE: tb/tb_nfa_state_set_simulator.sv
`timescale 1ns / 100ps

module tb_nfa_state_set_simulator;
    import nfa_pkg::*;

    localparam int STATES      = 16;
    localparam int SYMBOLS     = 8;
    localparam int ROWS        = STATES * SYMBOLS;
    localparam int PER_PHASE   = 67;     // random items per register setting
    localparam int PHASES      = 6;      // two settings per idle pattern
    localparam int STALL_LIMIT = 3000;   // cycles with no transfer at all
    localparam int TAIL_CYCLES = 30;     // idle margin at the end of the run

    // one result as the output channel carries it
    typedef struct packed {
        logic [ACTIVE_W-1:0] active;
        logic                accepted;
        logic                invalid;
    } t_status;

    // expectation typed into the directed table, or left to the predictor
    typedef struct {
        bit      known;
        t_status status;
    } t_known;

    // one row of the directed table
    typedef struct {
        t_op                 op;
        logic [CHAR_W-1:0]   char_byte;
        logic [RSTATE_W-1:0] row_state;
        logic [RSYM_W-1:0]   row_symbol;
        logic [ACTIVE_W-1:0] row_targets;
        bit                  reconfig;
        t_known              want;
    } t_vector;

    localparam t_status ST_HOME     = t_status'{16'h0001, 1'b0, 1'b0};
    localparam t_status ST_HOME_BAD = t_status'{16'h0001, 1'b0, 1'b1};

    // directed symbol codes: 0x00, 0xff, 'a' twice, 'b', 0x80, 0x7f, 'c'
    localparam logic [CODES_W-1:0] DIR_CODES = 64'h637F_8062_6161_FF00;

    logic i_clk;
    logic i_rst_n;

    nfa_in_if  in_ch ();
    nfa_out_if out_ch ();
    nfa_cfg_if cfg_ch ();

    nfa_state_set_simulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // predictor: own copy of the registers, the active set and the rows
    // ------------------------------------------------------------------
    logic [CODES_W-1:0]  sym_codes;
    logic [NSYM_W-1:0]   sym_count;
    logic [MASK_W-1:0]   accept_mask;
    logic [ACTIVE_W-1:0] cur_set;
    logic                bad_byte;
    logic [ACTIVE_W-1:0] row_mem [ROWS];

    t_known   known_status [$];   // one per item handed to the input channel
    t_status  pending      [$];   // results still owed by the block
    t_vector  directed     [$];

    int src_idle;
    int snk_idle;
    int errors;
    int results;
    int n_steps, n_loads, n_starts, n_other;
    int n_settings;
    int quiet;

    // symbols actually in use, saturated at the symbol count
    function automatic int live_symbols();
        return (sym_count > SYMBOLS) ? SYMBOLS : int'(sym_count);
    endfunction

    // applies one item to the predictor and returns the status after it
    function automatic t_status apply_item(t_op op, logic [CHAR_W-1:0] ch,
                                           logic [RSTATE_W-1:0] rs,
                                           logic [RSYM_W-1:0] rsym,
                                           logic [ACTIVE_W-1:0] rt);
        int                  hit;
        int                  j;
        int                  s;
        logic [ACTIVE_W-1:0] nxt;
        t_status             st;
        hit = -1;
        case (op)
            OP_START: begin
                cur_set  = 16'h0001;
                bad_byte = 1'b0;
            end
            OP_STEP: begin
                // scan downward so the lowest matching index wins
                for (j = live_symbols() - 1; j >= 0; j--) begin
                    if (sym_codes[8*j +: 8] == ch) hit = j;
                end
                if (hit < 0) begin
                    bad_byte = 1'b1;
                end else begin
                    nxt = '0;
                    for (s = 0; s < STATES; s++) begin
                        if (cur_set[s]) nxt |= row_mem[s*SYMBOLS + hit];
                    end
                    cur_set = nxt;
                end
            end
            OP_LOAD: begin
                row_mem[int'(rs)*SYMBOLS + int'(rsym)] = rt;
            end
            default: ;
        endcase
        st.active   = cur_set;
        st.accepted = (|(cur_set & accept_mask)) && !bad_byte;
        st.invalid  = bad_byte;
        return st;
    endfunction

    function automatic void apply_cfg(t_cfg_index idx, logic [CODES_W-1:0] data);
        case (idx)
            CFG_SYMBOL_CODES:   sym_codes   = data;
            CFG_SYMBOLS_IN_USE: sym_count   = data[NSYM_W-1:0];
            CFG_FINAL_MASK:     accept_mask = data[MASK_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void add_vector(t_op op, logic [CHAR_W-1:0] ch,
                                       logic [RSTATE_W-1:0] rs, logic [RSYM_W-1:0] rsym,
                                       logic [ACTIVE_W-1:0] rt, bit reconfig = 1'b0,
                                       bit known = 1'b0, t_status st = '0);
        t_vector v;
        v.op          = op;
        v.char_byte   = ch;
        v.row_state   = rs;
        v.row_symbol  = rsym;
        v.row_targets = rt;
        v.reconfig    = reconfig;
        v.want.known  = known;
        v.want.status = st;
        directed.push_back(v);
    endfunction

    // ------------------------------------------------------------------
    // clock, sink side and the checker
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // receiver stalls at random, per the current idle pattern
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end

    // everything sampled at the edge, before the block's outputs move
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        t_known  k;
        bit      xfer;
        xfer = 1'b0;

        // result transfer: compare with the oldest expectation
        if (out_ch.valid && out_ch.ready) begin
            xfer         = 1'b1;
            results++;
            got.active   = out_ch.active_states;
            got.accepted = out_ch.accepted;
            got.invalid  = out_ch.invalid;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result active %h accepted %b invalid %b",
                         $time, got.active, got.accepted, got.invalid);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.active !== want.active) begin
                    $display("%0t: active_states expected %h got %h",
                             $time, want.active, got.active);
                    errors++;
                end
                if (got.accepted !== want.accepted) begin
                    $display("%0t: accepted expected %b got %b",
                             $time, want.accepted, got.accepted);
                    errors++;
                end
                if (got.invalid !== want.invalid) begin
                    $display("%0t: invalid expected %b got %b",
                             $time, want.invalid, got.invalid);
                    errors++;
                end
            end
        end

        // item transfer: predict, a typed expectation overrides the prediction
        if (in_ch.valid && in_ch.ready) begin
            xfer = 1'b1;
            k    = known_status.pop_front();
            want = apply_item(in_ch.op, in_ch.char_byte, in_ch.row_state,
                              in_ch.row_symbol, in_ch.row_targets);
            pending.push_back(k.known ? k.status : want);
            case (in_ch.op)
                OP_STEP:  n_steps++;
                OP_LOAD:  n_loads++;
                OP_START: n_starts++;
                default:  n_other++;
            endcase
        end

        // register write
        if (cfg_ch.valid && cfg_ch.ready) begin
            xfer = 1'b1;
            apply_cfg(cfg_ch.index, cfg_ch.data);
        end

        // watchdog on cycles without any transfer
        if (xfer) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------

    // hands one item to the block, with a random gap in front of it
    task automatic send_item(t_op op, logic [CHAR_W-1:0] ch, logic [RSTATE_W-1:0] rs,
                             logic [RSYM_W-1:0] rsym, logic [ACTIVE_W-1:0] rt, t_known k);
        int gap;
        gap = 0;
        while (src_idle != 0 && $urandom_range(99) < src_idle) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        known_status.push_back(k);
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.char_byte   <= ch;
        in_ch.row_state   <= rs;
        in_ch.row_symbol  <= rsym;
        in_ch.row_targets <= rt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // holds the input back until every result is home; the item queue
    // covers an item taken at this very edge but not yet predicted
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending.size() != 0 || known_status.size() != 0) @(posedge i_clk);
    endtask

    // writes all registers, and the unused index too when asked
    task automatic write_regs(logic [CODES_W-1:0] codes, logic [CODES_W-1:0] count,
                              logic [CODES_W-1:0] mask, bit poke_unused);
        t_cfg_index         idx [4];
        logic [CODES_W-1:0] val [4];
        int                 n;
        int                 i;
        idx[0] = CFG_SYMBOL_CODES;   val[0] = codes;
        idx[1] = CFG_SYMBOLS_IN_USE; val[1] = count;
        idx[2] = CFG_FINAL_MASK;     val[2] = mask;
        idx[3] = CFG_UNUSED;         val[3] = {$urandom, $urandom};
        n = poke_unused ? 4 : 3;
        for (i = 0; i < n; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int                  ph;
        int                  i;
        int                  r;
        int                  live;
        t_op                 op;
        logic [CHAR_W-1:0]   ch;
        logic [RSTATE_W-1:0] rs;
        logic [RSYM_W-1:0]   rsym;
        logic [ACTIVE_W-1:0] rt;
        logic [CODES_W-1:0]  codes;
        logic [CODES_W-1:0]  count;
        logic [CODES_W-1:0]  mask;
        t_known              none;
        int                  nsym_pick [PHASES];
        logic [MASK_W-1:0]   mask_pick [PHASES];

        // all block inputs known from time zero
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_START;
        in_ch.char_byte    = '0;
        in_ch.row_state    = '0;
        in_ch.row_symbol   = '0;
        in_ch.row_targets  = '0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_SYMBOL_CODES;
        cfg_ch.data        = '0;

        // predictor after reset
        sym_codes   = '0;
        sym_count   = '0;
        accept_mask = '0;
        cur_set     = 16'h0001;
        bad_byte    = 1'b0;
        for (i = 0; i < ROWS; i++) row_mem[i] = '0;

        errors     = 0;
        results    = 0;
        n_steps    = 0;
        n_loads    = 0;
        n_starts   = 0;
        n_other    = 0;
        n_settings = 0;
        quiet      = 0;
        none.known  = 1'b0;
        none.status = '0;

        // first idle pattern: sender idles a little, receiver a lot
        src_idle = 23;
        snk_idle = 72;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, registers still at reset: nothing matches
        add_vector(OP_START, 8'h00, 4'd0, 3'd0, 16'h0000, 0, 1, ST_HOME);
        add_vector(OP_STEP,  8'h41, 4'd0, 3'd0, 16'h0000, 0, 1, ST_HOME_BAD);
        add_vector(OP_NONE,  8'hFF, 4'd9, 3'd5, 16'hA5A5, 0, 1, ST_HOME_BAD);
        add_vector(OP_START, 8'h00, 4'd0, 3'd0, 16'h0000, 0, 1, ST_HOME);
        add_vector(OP_LOAD,  8'h00, 4'd15, 3'd7, 16'hFFFF, 0, 1, ST_HOME);
        add_vector(OP_LOAD,  8'hFF, 4'd0, 3'd0, 16'h0000, 0, 1, ST_HOME);
        // directed codes loaded: duplicate 'a', too many symbols in use
        add_vector(OP_LOAD,  8'h00, 4'd0, 3'd2, 16'h0006, 1);
        add_vector(OP_LOAD,  8'h00, 4'd1, 3'd2, 16'h0004);
        add_vector(OP_LOAD,  8'h00, 4'd2, 3'd2, 16'h8004);
        add_vector(OP_LOAD,  8'h00, 4'd0, 3'd3, 16'h0100);   // shadowed by 'a' at index 2
        add_vector(OP_STEP,  8'h61, 4'd0, 3'd0, 16'h0000);   // {1,2}
        add_vector(OP_STEP,  8'h61, 4'd0, 3'd0, 16'h0000);   // both reach 2, union
        add_vector(OP_STEP,  8'hFF, 4'd0, 3'd0, 16'h0000);   // set goes empty
        add_vector(OP_STEP,  8'h00, 4'd0, 3'd0, 16'h0000);   // empty stays empty
        add_vector(OP_START, 8'h00, 4'd0, 3'd0, 16'h0000);
        add_vector(OP_LOAD,  8'h00, 4'd0, 3'd7, 16'hFFFF);
        add_vector(OP_STEP,  8'h63, 4'd0, 3'd0, 16'h0000);   // every state active
        add_vector(OP_STEP,  8'h42, 4'd0, 3'd0, 16'h0000);   // unknown byte, set kept
        add_vector(OP_STEP,  8'h63, 4'd0, 3'd0, 16'h0000);   // still advances, flag sticks
        add_vector(OP_START, 8'h00, 4'd0, 3'd0, 16'h0000);
        add_vector(OP_LOAD,  8'h00, 4'd15, 3'd0, 16'h0001);
        add_vector(OP_LOAD,  8'h00, 4'd0, 3'd0, 16'h8000);
        add_vector(OP_STEP,  8'h00, 4'd0, 3'd0, 16'h0000);   // into the top state
        add_vector(OP_STEP,  8'h00, 4'd0, 3'd0, 16'h0000);   // and back home
        add_vector(OP_NONE,  8'h5A, 4'd3, 3'd1, 16'h1234);

        foreach (directed[k]) begin
            if (directed[k].reconfig) begin
                drain();
                write_regs(DIR_CODES, 64'hF, 64'h8004, 1'b1);
            end
            send_item(directed[k].op, directed[k].char_byte, directed[k].row_state,
                      directed[k].row_symbol, directed[k].row_targets, directed[k].want);
        end

        // random part: two register settings per idle pattern
        nsym_pick = '{8, 3, 15, 1, 5, 8};
        mask_pick[0] = 16'hFFFF;
        mask_pick[1] = MASK_W'($urandom);
        mask_pick[2] = 16'h0000;
        mask_pick[3] = MASK_W'($urandom);
        mask_pick[4] = MASK_W'($urandom);
        mask_pick[5] = MASK_W'($urandom);

        for (ph = 0; ph < PHASES; ph++) begin
            // the sender pauses here until every result is back
            drain();
            if (ph == 2) begin
                src_idle = 72;
                snk_idle = 23;
            end else if (ph == 4) begin
                src_idle = 0;
                snk_idle = 0;
            end
            codes = {$urandom, $urandom};
            count = {$urandom, $urandom};
            count[NSYM_W-1:0] = NSYM_W'(nsym_pick[ph]);
            mask  = {$urandom, $urandom};
            mask[MASK_W-1:0] = mask_pick[ph];
            write_regs(codes, count, mask, ph == 3);
            live = (nsym_pick[ph] > SYMBOLS) ? SYMBOLS : nsym_pick[ph];

            for (i = 0; i < PER_PHASE; i++) begin
                r    = $urandom_range(99);
                ch   = CHAR_W'($urandom);
                rs   = RSTATE_W'($urandom);
                rsym = RSYM_W'($urandom);
                // mostly sparse targets so the active set stays interesting
                case ($urandom_range(3))
                    0: rt = 16'h0001 << $urandom_range(15);
                    1: rt = (16'h0001 << $urandom_range(15)) | (16'h0001 << $urandom_range(15));
                    2: rt = ACTIVE_W'($urandom);
                    default: rt = '0;
                endcase
                if (r < 8)       op = OP_START;
                else if (r < 12) op = OP_NONE;
                else if (r < 37) op = OP_LOAD;
                else             op = OP_STEP;
                // most steps use a live code, most loads a live symbol
                if (op == OP_STEP && live > 0 && $urandom_range(9) < 8)
                    ch = codes[8*$urandom_range(live-1) +: 8];
                if (op == OP_LOAD && live > 0 && $urandom_range(9) < 8)
                    rsym = RSYM_W'($urandom_range(live-1));
                send_item(op, ch, rs, rsym, rt, none);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d steps, %0d loads, %0d starts, %0d unused ops, %0d results",
                 n_steps, n_loads, n_starts, n_other, results);
        $display("run: %0d register settings, three handshake idle patterns",
                 n_settings);
        if (errors == 0 && pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
